@@ rtl/dott_pkg.sv @@
// Shared types and constants for the deadline-ordered task table.
`default_nettype none

package dott_pkg;

    localparam int IDENT_W  = 16;
    localparam int TIME_W   = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 5;
    localparam int COUNT_W  = 16;

    localparam logic [OP_W-1:0] OP_CREATE   = 2'd0;
    localparam logic [OP_W-1:0] OP_COMPLETE = 2'd1;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd2;

    // One table slot.
    typedef struct packed {
        logic               valid;
        logic [IDENT_W-1:0] ident;
        logic [TIME_W-1:0]  deadline;
        logic [TIME_W-1:0]  rel_tick;
    } entry_t;

    // Operands broadcast to every cell.
    typedef struct packed {
        logic [IDENT_W-1:0] ident;
        logic [TIME_W-1:0]  deadline;
        logic [TIME_W-1:0]  now;
    } key_t;

    // Search result handed from cell to cell during an id scan.
    typedef struct packed {
        logic              found;
        logic [TIME_W-1:0] rel_tick;
    } carry_t;

    // Command broadcast to every cell in a cycle.
    typedef enum logic [2:0] {
        CMD_HOLD   = 3'd0,
        CMD_SHIFT  = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_CLEAR  = 3'd3,
        CMD_SCAN   = 3'd4,
        CMD_REMOVE = 3'd5
    } cell_cmd_t;

endpackage

`default_nettype wire

@@ rtl/deadline_ordered_task_table_unit.sv @@
// Top level of the deadline-ordered task table: control sequencer and cell chain.
//
// The table is a chain of MAX_TASKS cells kept sorted by deadline, head in
// cell 0, which is the running task. One item is worked at a time. Each item
// first retires an overdue head, then runs its operation. A create, or any
// operation other than a complete, then goes straight to the finish step; a
// complete first runs the id scan, in which the first-match flag and its
// release tick travel down the chain one cell per cycle, and then the removal
// closes the gap in a single shift. A finished item waits as long as the
// previous result still blocks the output register. Input stall is low only
// while the sequencer is idle. The result sits in an output register, so the
// next item is accepted while a finished result still waits to be taken.
// Slot contents have no reset; only the per-slot valid bits, the scan carries,
// the counters, the sequencer state and the output valid bit are cleared, and
// no clearing pass is needed after reset.
`default_nettype none

module deadline_ordered_task_table_unit #(
    parameter int MAX_TASKS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [dott_pkg::OP_W-1:0]      operation,
    input  wire logic [dott_pkg::TIME_W-1:0]    now,
    input  wire logic [dott_pkg::IDENT_W-1:0]   task_ident,
    input  wire logic [dott_pkg::TIME_W-1:0]    deadline,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [dott_pkg::STATUS_W-1:0]       status,
    output logic                                running_valid,
    output logic [dott_pkg::IDENT_W-1:0]        running_ident,
    output logic                                overdue_valid,
    output logic [dott_pkg::IDENT_W-1:0]        overdue_ident,
    output logic                                done_valid,
    output logic [dott_pkg::TIME_W-1:0]         done_release,
    output logic [dott_pkg::TOTAL_W-1:0]        active_total,
    output logic [dott_pkg::COUNT_W-1:0]        completed_total,
    output logic [dott_pkg::COUNT_W-1:0]        overdue_total
);
    import dott_pkg::*;

    localparam int OCC_W  = $clog2(MAX_TASKS + 1);
    localparam int SCAN_W = $clog2(MAX_TASKS);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_RETIRE = 6'b000010,
        S_OPER   = 6'b000100,
        S_SCAN   = 6'b001000,
        S_REMOVE = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Item under work.
    logic [OP_W-1:0]     op_reg, op_next;
    key_t                key_reg, key_next;
    logic [SCAN_W-1:0]   scan_reg, scan_next;

    // Table totals.
    logic [OCC_W-1:0]    occ_reg, occ_next;
    logic [COUNT_W-1:0]  comp_cnt_reg, comp_cnt_next;
    logic [COUNT_W-1:0]  ovd_cnt_reg, ovd_cnt_next;

    // Per-item result fields being built.
    logic [STATUS_W-1:0] st_reg, st_next;
    logic                ov_v_reg, ov_v_next;
    logic [IDENT_W-1:0]  ov_id_reg, ov_id_next;
    logic                dn_v_reg, dn_v_next;
    logic [TIME_W-1:0]   dn_rel_reg, dn_rel_next;

    // Output register.
    logic                out_v_reg, out_v_next;
    logic [STATUS_W-1:0] o_status_reg;
    logic                o_run_v_reg;
    logic [IDENT_W-1:0]  o_run_id_reg;
    logic                o_ov_v_reg;
    logic [IDENT_W-1:0]  o_ov_id_reg;
    logic                o_dn_v_reg;
    logic [TIME_W-1:0]   o_dn_rel_reg;
    logic [TOTAL_W-1:0]  o_active_reg;
    logic [COUNT_W-1:0]  o_comp_reg;
    logic [COUNT_W-1:0]  o_ovd_reg;

    cell_cmd_t cmd;
    logic      load_out;
    logic      in_accept;
    logic      overdue;
    logic      full;
    carry_t    scan_tail;

    entry_t entry_w [MAX_TASKS];
    logic   keep_w  [MAX_TASKS];
    carry_t carry_w [MAX_TASKS];

    // Cell chain: each cell sees its neighbors' slots, keep flag and scan carry.
    // The head sees a keeping neighbor, so it takes a new task that lands first.
    for (genvar g = 0; g < MAX_TASKS; g++)
    begin : g_cell
        entry_t left_e, right_e;
        logic   left_k;
        carry_t left_c;

        if (g == 0)
        begin : g_head
            assign left_e = '0;
            assign left_k = 1'b1;
            assign left_c = '0;
        end
        else
        begin : g_body
            assign left_e = entry_w[g-1];
            assign left_k = keep_w[g-1];
            assign left_c = carry_w[g-1];
        end

        if (g == MAX_TASKS - 1)
        begin : g_tail
            assign right_e = '0;
        end
        else
        begin : g_mid
            assign right_e = entry_w[g+1];
        end

        dott_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .key         (key_reg),
            .left_entry  (left_e),
            .right_entry (right_e),
            .left_keep   (left_k),
            .left_carry  (left_c),
            .entry       (entry_w[g]),
            .keep        (keep_w[g]),
            .carry       (carry_w[g])
        );
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign overdue   = entry_w[0].valid && (key_reg.now > entry_w[0].deadline);
    assign full      = entry_w[MAX_TASKS-1].valid;
    assign scan_tail = carry_w[MAX_TASKS-1];
    assign load_out  = (state_reg == S_FINISH) && (!out_v_reg || !out_stall);

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        scan_next     = scan_reg;
        occ_next      = occ_reg;
        comp_cnt_next = comp_cnt_reg;
        ovd_cnt_next  = ovd_cnt_reg;
        st_next       = st_reg;
        ov_v_next     = ov_v_reg;
        ov_id_next    = ov_id_reg;
        dn_v_next     = dn_v_reg;
        dn_rel_next   = dn_rel_reg;
        cmd           = CMD_HOLD;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    op_next     = operation;
                    key_next    = '{ident: task_ident, deadline: deadline, now: now};
                    st_next     = STATUS_OK;
                    ov_v_next   = 1'b0;
                    ov_id_next  = '0;
                    dn_v_next   = 1'b0;
                    dn_rel_next = '0;
                    state_next  = S_RETIRE;
                end
            end
            S_RETIRE:
            begin
                // Drop a head whose deadline has strictly passed.
                if (overdue)
                begin
                    cmd          = CMD_SHIFT;
                    ov_v_next    = 1'b1;
                    ov_id_next   = entry_w[0].ident;
                    occ_next     = occ_reg - 1'b1;
                    ovd_cnt_next = (ovd_cnt_reg == '1) ? ovd_cnt_reg
                                                       : ovd_cnt_reg + 1'b1;
                end
                state_next = S_OPER;
            end
            S_OPER:
            begin
                case (op_reg)
                    OP_CREATE:
                    begin
                        if (full)
                        begin
                            st_next = STATUS_FULL;
                        end
                        else
                        begin
                            cmd      = CMD_INSERT;
                            occ_next = occ_reg + 1'b1;
                        end
                        state_next = S_FINISH;
                    end
                    OP_COMPLETE:
                    begin
                        cmd        = CMD_CLEAR;
                        scan_next  = '0;
                        state_next = S_SCAN;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_SCAN:
            begin
                // Advance the first-match flag one cell per cycle.
                cmd       = CMD_SCAN;
                scan_next = scan_reg + 1'b1;
                if (scan_reg == SCAN_W'(MAX_TASKS - 1))
                begin
                    state_next = S_REMOVE;
                end
            end
            S_REMOVE:
            begin
                if (scan_tail.found)
                begin
                    cmd           = CMD_REMOVE;
                    dn_v_next     = 1'b1;
                    dn_rel_next   = scan_tail.rel_tick;
                    occ_next      = occ_reg - 1'b1;
                    comp_cnt_next = (comp_cnt_reg == '1) ? comp_cnt_reg
                                                         : comp_cnt_reg + 1'b1;
                end
                else
                begin
                    st_next = STATUS_MISSING;
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_v_next = out_v_reg;
        if (out_v_reg && !out_stall)
        begin
            out_v_next = 1'b0;
        end
        if (load_out)
        begin
            out_v_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            occ_reg      <= '0;
            comp_cnt_reg <= '0;
            ovd_cnt_reg  <= '0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            occ_reg      <= occ_next;
            comp_cnt_reg <= comp_cnt_next;
            ovd_cnt_reg  <= ovd_cnt_next;
            out_v_reg    <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        scan_reg   <= scan_next;
        st_reg     <= st_next;
        ov_v_reg   <= ov_v_next;
        ov_id_reg  <= ov_id_next;
        dn_v_reg   <= dn_v_next;
        dn_rel_reg <= dn_rel_next;
        if (load_out)
        begin
            o_status_reg <= st_reg;
            o_run_v_reg  <= entry_w[0].valid;
            o_run_id_reg <= entry_w[0].valid ? entry_w[0].ident : '0;
            o_ov_v_reg   <= ov_v_reg;
            o_ov_id_reg  <= ov_id_reg;
            o_dn_v_reg   <= dn_v_reg;
            o_dn_rel_reg <= dn_rel_reg;
            o_active_reg <= TOTAL_W'(occ_reg);
            o_comp_reg   <= comp_cnt_reg;
            o_ovd_reg    <= ovd_cnt_reg;
        end
    end

    assign out_valid       = out_v_reg;
    assign status          = o_status_reg;
    assign running_valid   = o_run_v_reg;
    assign running_ident   = o_run_id_reg;
    assign overdue_valid   = o_ov_v_reg;
    assign overdue_ident   = o_ov_id_reg;
    assign done_valid      = o_dn_v_reg;
    assign done_release    = o_dn_rel_reg;
    assign active_total    = o_active_reg;
    assign completed_total = o_comp_reg;
    assign overdue_total   = o_ovd_reg;

    // Checks on the sequencer and the chain.
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(MAX_TASKS))
        else $error("occupancy above table depth");

    a_head_matches_occ: assert property (@(posedge clk) disable iff (!rst_n)
        entry_w[0].valid == (occ_reg != '0))
        else $error("head valid disagrees with occupancy");

    a_tail_matches_full: assert property (@(posedge clk) disable iff (!rst_n)
        entry_w[MAX_TASKS-1].valid == (occ_reg == OCC_W'(MAX_TASKS)))
        else $error("tail valid disagrees with occupancy");

    a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |=> (state_reg == S_SCAN || state_reg == S_REMOVE))
        else $error("scan left early");

endmodule

`default_nettype wire

@@ rtl/dott_cell.sv @@
// One slot of the sorted task chain, with its insert, shift and scan logic.
`default_nettype none

module dott_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dott_pkg::cell_cmd_t cmd,
    input  wire dott_pkg::key_t      key,
    input  wire dott_pkg::entry_t    left_entry,
    input  wire dott_pkg::entry_t    right_entry,
    input  wire logic               left_keep,
    input  wire dott_pkg::carry_t    left_carry,
    output dott_pkg::entry_t         entry,
    output logic                    keep,
    output dott_pkg::carry_t         carry
);
    import dott_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    entry_t data_reg;
    entry_t data_next;
    carry_t carry_reg;
    carry_t carry_next;
    logic   match;

    assign entry = '{valid: valid_reg, ident: data_reg.ident,
                     deadline: data_reg.deadline, rel_tick: data_reg.rel_tick};
    assign carry = carry_reg;

    // Stay ahead of a new task whose deadline is equal or later.
    assign keep  = valid_reg && (data_reg.deadline <= key.deadline);
    assign match = valid_reg && (data_reg.ident == key.ident);

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        carry_next = carry_reg;
        case (cmd)
            CMD_SHIFT:
            begin
                valid_next = right_entry.valid;
                data_next  = right_entry;
            end
            CMD_INSERT:
            begin
                if (!keep)
                begin
                    if (left_keep)
                    begin
                        valid_next = 1'b1;
                        data_next  = '{valid: 1'b1, ident: key.ident,
                                       deadline: key.deadline, rel_tick: key.now};
                    end
                    else
                    begin
                        valid_next = left_entry.valid;
                        data_next  = left_entry;
                    end
                end
            end
            CMD_CLEAR:
            begin
                carry_next.found = 1'b0;
            end
            CMD_SCAN:
            begin
                carry_next.found    = left_carry.found || match;
                carry_next.rel_tick = left_carry.found ? left_carry.rel_tick
                                                       : data_reg.rel_tick;
            end
            CMD_REMOVE:
            begin
                // Close the gap at and after the first matching slot.
                if (left_carry.found || match)
                begin
                    valid_next = right_entry.valid;
                    data_next  = right_entry;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            carry_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            carry_reg <= carry_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire
